// File: src/dmi_pkg.sv
// ----------------------------------------------------------------------------
// dmi_pkg
// Shared widths, register indexes, reset values, and saturation and magnitude helpers of the
// damped mass integrator.
// ----------------------------------------------------------------------------
package dmi_pkg;

	localparam int DataW = 32;
	localparam int CfgIdxW = 2;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] RegMass = 2'd0;
	localparam logic [CfgIdxW-1:0] RegDamping = 2'd1;
	localparam logic [CfgIdxW-1:0] RegTimeStep = 2'd2;
	localparam logic [CfgIdxW-1:0] RegMethod = 2'd3;

	localparam logic [DataW-1:0] MassReset = 32'd65536;
	localparam logic [DataW-1:0] DampingReset = 32'd0;
	localparam logic [DataW-1:0] TimeStepReset = 32'd4294967;

	localparam logic MethodEuler = 1'b0;
	localparam logic MethodRk4 = 1'b1;

	// Damping quotient clamp, 2^62.
	localparam logic [63:0] T2Limit = 64'h4000_0000_0000_0000;
	localparam logic [31:0] SixDiv = 32'd6;

	typedef logic signed [DataW-1:0] q16_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		logic signed [31:0] r;
		if (x > 68'sh0_0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -68'sh0_0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

endpackage

// File: src/damped_mass_integrator_unit.sv
// ----------------------------------------------------------------------------
// damped_mass_integrator_unit
// Advances a damped mass by one Euler or Runge-Kutta step per force item.
// ----------------------------------------------------------------------------
// Each accepted force item advances the stored position and velocity by one
// step and returns both, saturated to signed Q16.16. One 32x32 multiplier and
// one radix-2 divider are shared under a sequencer, and the divider sets the
// rate: a forward Euler item needs two divisions and a Runge-Kutta item six.
// The input side is ready only while the sequencer is idle; a finished result waits
// in the output register, and the next item may be taken in the meantime.
module damped_mass_integrator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [dmi_pkg::DataW-1:0]     s_axis_tdata,  // [31:0] force_req
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [2*dmi_pkg::DataW-1:0]   m_axis_tdata,  // [31:0] position, [63:32] velocity
	input  logic                          cfg_we,
	input  logic [dmi_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [dmi_pkg::DataW-1:0]     cfg_wdata
);
	import dmi_pkg::*;

	localparam logic [4:0] StIdle    = 5'd0;
	localparam logic [4:0] StT1      = 5'd1;
	localparam logic [4:0] StT1Done  = 5'd2;
	localparam logic [4:0] StDt6Done = 5'd3;
	localparam logic [4:0] StAccM    = 5'd4;
	localparam logic [4:0] StAccD    = 5'd5;
	localparam logic [4:0] StAccDone = 5'd6;
	localparam logic [4:0] StEuP     = 5'd7;
	localparam logic [4:0] StEuPDone = 5'd8;
	localparam logic [4:0] StRkSum   = 5'd9;
	localparam logic [4:0] StRkXv    = 5'd10;
	localparam logic [4:0] StRkPDone = 5'd11;
	localparam logic [4:0] StOut     = 5'd12;
	localparam logic [4:0] StDivW    = 5'd13;
	localparam logic [4:0] StScLo    = 5'd14;
	localparam logic [4:0] StScHi    = 5'd15;
	localparam logic [4:0] StScAcc   = 5'd16;
	localparam logic [4:0] StScRnd   = 5'd17;
	localparam logic [4:0] StScAdd   = 5'd18;

	logic [4:0]  state_q, ret_q;
	logic [31:0] mass_q, damping_q, time_step_q;
	logic        method_q;

	q16_t        pos_q, vel_q, np_q, f_q, xv_q, kv_q, sres_q, sc_base_q;
	logic        out_valid_q;
	logic signed [48:0] t1_q;
	logic [31:0] dt6_q;
	logic [1:0]  stage_q;
	logic signed [35:0] sp_q, sv_q;

	// Divider
	logic [63:0] dvd_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_sh;
	logic        rem_ge;

	// Multiplier and scaler
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_s1;
	logic [66:0] acc_q;
	logic [35:0] r_q;
	logic [34:0] sc_mag_q;
	logic        sc_neg_q, sc_sh33_q;
	logic [31:0] sc_k_q;

	logic [31:0] m_eff;
	logic [63:0] qc;
	logic signed [65:0] t2_s, acc_diff;
	logic signed [67:0] rnd_sum, add_val, add_sum;
	logic signed [35:0] sum_in_p, sum_in_v, sp_sum, sv_sel;
	logic        w_two;

	assign s_axis_tready = (state_q == StIdle);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {vel_q, pos_q};
	assign m_eff = (mass_q == 32'd0) ? 32'd1 : mass_q;

	assign rem_sh = {rem_q[31:0], dvd_q[63]};
	assign rem_ge = (rem_sh >= {1'b0, div_q});

	always_comb begin
		mul_a = mag32(xv_q);
		mul_b = damping_q;
		case (state_q)
			StScLo: begin
				mul_a = sc_mag_q[31:0];
				mul_b = sc_k_q;
			end
			StScHi: begin
				mul_a = {29'd0, sc_mag_q[34:32]};
				mul_b = sc_k_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		qc = (dvd_q > T2Limit) ? T2Limit : dvd_q;
		t2_s = xv_q[31] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
		acc_diff = {{17{t1_q[48]}}, t1_q} - t2_s;
		rnd_sum = $signed({1'b0, acc_q}) + (sc_sh33_q ? 68'sh1_0000_0000 : 68'sh8000_0000);
		add_val = sc_neg_q ? -$signed({32'd0, r_q}) : $signed({32'd0, r_q});
		add_sum = {{36{sc_base_q[31]}}, sc_base_q} + add_val;
		w_two = (stage_q == 2'd1) || (stage_q == 2'd2);
		sum_in_p = {{4{xv_q[31]}}, xv_q};
		sum_in_v = {{4{kv_q[31]}}, kv_q};
		if (w_two) begin
			sum_in_p = sum_in_p <<< 1;
			sum_in_v = sum_in_v <<< 1;
		end
		sp_sum = sp_q + sum_in_p;
		sv_sel = sv_q + sum_in_v;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q      <= MassReset;
			damping_q   <= DampingReset;
			time_step_q <= TimeStepReset;
			method_q    <= MethodEuler;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMass:     mass_q <= cfg_wdata;
				RegDamping:  damping_q <= cfg_wdata;
				RegTimeStep: time_step_q <= cfg_wdata;
				RegMethod:   method_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			ret_q       <= StIdle;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			vel_q       <= '0;
			cnt_q       <= '0;
			stage_q     <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != StOut))
				out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (s_axis_tvalid) begin
						f_q     <= s_axis_tdata;
						xv_q    <= vel_q;
						stage_q <= '0;
						sp_q    <= '0;
						sv_q    <= '0;
						state_q <= StT1;
					end
				end
				StT1: begin
					dvd_q   <= {16'd0, mag32(f_q), 16'd0};
					rem_q   <= '0;
					div_q   <= m_eff;
					cnt_q   <= 6'd63;
					ret_q   <= StT1Done;
					state_q <= StDivW;
				end
				StDivW: begin
					rem_q <= rem_ge ? rem_sh - {1'b0, div_q} : rem_sh;
					dvd_q <= {dvd_q[62:0], rem_ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						state_q <= ret_q;
				end
				StT1Done: begin
					t1_q <= f_q[31] ? -$signed({1'b0, dvd_q[47:0]})
					                : $signed({1'b0, dvd_q[47:0]});
					if (method_q == MethodRk4) begin
						dvd_q   <= {31'd0, 33'(time_step_q) + 33'd3};
						rem_q   <= '0;
						div_q   <= SixDiv;
						cnt_q   <= 6'd63;
						ret_q   <= StDt6Done;
						state_q <= StDivW;
					end else begin
						state_q <= StAccM;
					end
				end
				StDt6Done: begin
					dt6_q   <= dvd_q[31:0];
					state_q <= StAccM;
				end
				StAccM: state_q <= StAccD;
				StAccD: begin
					dvd_q   <= prod_s1;
					rem_q   <= '0;
					div_q   <= m_eff;
					cnt_q   <= 6'd63;
					ret_q   <= StAccDone;
					state_q <= StDivW;
				end
				StAccDone: begin
					kv_q    <= sat32({{2{acc_diff[65]}}, acc_diff});
					state_q <= (method_q == MethodRk4) ? StRkSum : StEuP;
				end
				StEuP: begin
					sc_mag_q  <= {3'd0, mag32(vel_q)};
					sc_neg_q  <= vel_q[31];
					sc_k_q    <= time_step_q;
					sc_sh33_q <= 1'b0;
					sc_base_q <= pos_q;
					ret_q     <= StEuPDone;
					state_q   <= StScLo;
				end
				StEuPDone: begin
					np_q      <= sres_q;
					sc_mag_q  <= {3'd0, mag32(kv_q)};
					sc_neg_q  <= kv_q[31];
					sc_k_q    <= time_step_q;
					sc_sh33_q <= 1'b0;
					sc_base_q <= vel_q;
					ret_q     <= StOut;
					state_q   <= StScLo;
				end
				StRkSum: begin
					sp_q <= sp_sum;
					sv_q <= sv_sel;
					sc_sh33_q <= 1'b0;
					if (stage_q == 2'd3) begin
						sc_mag_q  <= sp_sum[35] ? 35'(-sp_sum) : 35'(sp_sum);
						sc_neg_q  <= sp_sum[35];
						sc_k_q    <= dt6_q;
						sc_base_q <= pos_q;
						ret_q     <= StRkPDone;
					end else begin
						sc_mag_q  <= {3'd0, mag32(kv_q)};
						sc_neg_q  <= kv_q[31];
						sc_k_q    <= time_step_q;
						sc_sh33_q <= (stage_q != 2'd2);
						sc_base_q <= vel_q;
						ret_q     <= StRkXv;
					end
					state_q <= StScLo;
				end
				StRkXv: begin
					xv_q    <= sres_q;
					stage_q <= stage_q + 2'd1;
					state_q <= StAccM;
				end
				StRkPDone: begin
					np_q      <= sres_q;
					sc_mag_q  <= sv_q[35] ? 35'(-sv_q) : 35'(sv_q);
					sc_neg_q  <= sv_q[35];
					sc_k_q    <= dt6_q;
					sc_sh33_q <= 1'b0;
					sc_base_q <= vel_q;
					ret_q     <= StOut;
					state_q   <= StScLo;
				end
				StScLo: state_q <= StScHi;
				StScHi: begin
					acc_q   <= {3'd0, prod_s1};
					state_q <= StScAcc;
				end
				StScAcc: begin
					acc_q   <= acc_q + {prod_s1[34:0], 32'd0};
					state_q <= StScRnd;
				end
				StScRnd: begin
					r_q     <= sc_sh33_q ? {1'b0, rnd_sum[67:33]} : rnd_sum[67:32];
					state_q <= StScAdd;
				end
				StScAdd: begin
					sres_q  <= sat32(add_sum);
					state_q <= ret_q;
				end
				StOut: begin
					// The previous result must be taken before the state moves on.
					if (!out_valid_q || m_axis_tready) begin
						pos_q       <= np_q;
						vel_q       <= sres_q;
						out_valid_q <= 1'b1;
						state_q     <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// A division always runs its full count before returning.
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StDivW && cnt_q != 6'd0) |=> (state_q == StDivW))
		else $error("divider left early");

	// A pending result is never overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StOut && out_valid_q && !m_axis_tready) |=>
		(state_q == StOut && $stable(pos_q) && $stable(vel_q)))
		else $error("result overwritten");

	// The dt/6 weight is only computed for a Runge-Kutta step.
	a_dt6_rk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StDt6Done || state_q == StRkSum) |-> (method_q == MethodRk4))
		else $error("Runge-Kutta path in Euler mode");

	// Every item starts its work with a fresh stage count.
	a_stage_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StT1) |-> (stage_q == 2'd0))
		else $error("stage count not cleared");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped mass integrator. Force items are streamed
// in under several mass, damping, step and method settings; a scoreboard
// advances its own copy of position and velocity for every accepted item and
// compares each returned pair with the oldest prediction.
// ----------------------------------------------------------------------------

class dmi_scoreboard;
	logic [31:0] mass_q;
	logic [31:0] damping_q;
	logic [31:0] step_q;
	logic method_q;
	dmi_pkg::q16_t pos_q;
	dmi_pkg::q16_t vel_q;
	logic [63:0] expected_states[$];

	function new();
		mass_q = dmi_pkg::MassReset;
		damping_q = dmi_pkg::DampingReset;
		step_q = dmi_pkg::TimeStepReset;
		method_q = dmi_pkg::MethodEuler;
		pos_q = '0;
		vel_q = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			dmi_pkg::RegMass: mass_q = val;
			dmi_pkg::RegDamping: damping_q = val;
			dmi_pkg::RegTimeStep: step_q = val;
			default: method_q = val[0];
		endcase
	endfunction

	function dmi_pkg::q16_t clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// Product scaled down by 2^sh, rounded to nearest with ties away from zero.
	function longint round_scale(longint x, logic [63:0] k, int sh);
		logic neg;
		logic [127:0] mag;
		logic [127:0] prod;
		neg = x < 0;
		mag = {64'd0, neg ? -x : x};
		prod = (mag * {64'd0, k} + (128'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function dmi_pkg::q16_t accel(dmi_pkg::q16_t f, dmi_pkg::q16_t v);
		longint m;
		longint t1;
		longint t2;
		m = (mass_q == 0) ? 64'sd1 : longint'({32'd0, mass_q});
		t1 = (longint'(f) * 64'sd65536) / m;
		t2 = (longint'({32'd0, damping_q}) * longint'(v)) / m;
		if (t2 > longint'(dmi_pkg::T2Limit)) t2 = longint'(dmi_pkg::T2Limit);
		if (t2 < -longint'(dmi_pkg::T2Limit)) t2 = -longint'(dmi_pkg::T2Limit);
		return clamp32(t1 - t2);
	endfunction

	// Advances the stored state by one step and queues the new pair.
	function void advance_state(dmi_pkg::q16_t f);
		logic [63:0] dt;
		logic [63:0] dt6;
		dmi_pkg::q16_t kv0, kv1, kv2, kv3, xv1, xv2, xv3, np, nv;
		longint sp;
		longint sv;
		dt = {32'd0, step_q};
		if (method_q == dmi_pkg::MethodRk4) begin
			dt6 = (dt + 3) / 6;
			kv0 = accel(f, vel_q);
			xv1 = clamp32(longint'(vel_q) + round_scale(kv0, dt, 33));
			kv1 = accel(f, xv1);
			xv2 = clamp32(longint'(vel_q) + round_scale(kv1, dt, 33));
			kv2 = accel(f, xv2);
			xv3 = clamp32(longint'(vel_q) + round_scale(kv2, dt, 32));
			kv3 = accel(f, xv3);
			// Position slopes are the velocities of the intermediate states.
			sp = longint'(vel_q) + 2 * longint'(xv1) + 2 * longint'(xv2) + longint'(xv3);
			sv = longint'(kv0) + 2 * longint'(kv1) + 2 * longint'(kv2) + longint'(kv3);
			np = clamp32(longint'(pos_q) + round_scale(sp, dt6, 32));
			nv = clamp32(longint'(vel_q) + round_scale(sv, dt6, 32));
		end else begin
			kv0 = accel(f, vel_q);
			np = clamp32(longint'(pos_q) + round_scale(vel_q, dt, 32));
			nv = clamp32(longint'(vel_q) + round_scale(kv0, dt, 32));
		end
		pos_q = np;
		vel_q = nv;
		expected_states.push_back({nv, np});
	endfunction

	// Returns 1 when no result was due, else a mask of wrong fields (bit 1
	// position, bit 2 velocity).
	function int check_state(logic [63:0] got, output logic [63:0] want);
		int bad;
		want = '0;
		if (expected_states.size() == 0) return 1;
		want = expected_states.pop_front();
		bad = 0;
		if (got[31:0] !== want[31:0]) bad |= 2;
		if (got[63:32] !== want[63:32]) bad |= 4;
		return bad;
	endfunction
endclass

module tb_top;
	import dmi_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	dmi_scoreboard sb = new();
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit gaps_on = 1'b1;

	damped_mass_integrator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 12) == 0) begin
			stall_left <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [63:0] want;
		int bad;
		if (m_axis_tvalid && m_axis_tready) begin
			bad = sb.check_state(m_axis_tdata, want);
			if (bad == 1) report_mismatch("unexpected item", m_axis_tdata, want);
			if (bad[1]) report_mismatch("position", {32'd0, m_axis_tdata[31:0]},
				{32'd0, want[31:0]});
			if (bad[2]) report_mismatch("velocity", {32'd0, m_axis_tdata[63:32]},
				{32'd0, want[63:32]});
		end
	end

	// Counts cycles without any accepted item on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("[damped_mass_integrator_unit] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_force(logic [31:0] f);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (!s_axis_tready);
		sb.advance_state(f);
	endtask

	// Holds off the sender until every predicted result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_states.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_force();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 1 << 20);
			2: return -$urandom_range(0, 1 << 20);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 1 << 24) - (1 << 23);
		endcase
	endfunction

	task automatic random_settings();
		case ($urandom_range(0, 3))
			0: write_reg(RegMass, $urandom());
			1: write_reg(RegMass, $urandom_range(1 << 12, 1 << 20));
			2: write_reg(RegMass, 32'd1);
			default: write_reg(RegMass, 32'hFFFF_FFFF);
		endcase
		case ($urandom_range(0, 2))
			0: write_reg(RegDamping, 32'd0);
			1: write_reg(RegDamping, $urandom_range(0, 1 << 20));
			default: write_reg(RegDamping, $urandom());
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(RegTimeStep, $urandom());
			1: write_reg(RegTimeStep, $urandom_range(0, 1 << 26));
			2: write_reg(RegTimeStep, 32'd0);
			default: write_reg(RegTimeStep, 32'hFFFF_FFFF);
		endcase
		write_reg(RegMethod, $urandom_range(0, 1) ? MethodRk4 : MethodEuler);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, forward Euler, force extremes.
		send_force(32'h0000_0000);
		send_force(32'h7FFF_FFFF);
		send_force(32'h8000_0000);
		send_force(32'h0001_0000);
		send_force(32'hFFFF_FFFF);
		drain();

		// Runge-Kutta with light damping and the longest step.
		write_reg(RegMethod, MethodRk4);
		write_reg(RegDamping, 32'h0000_8000);
		write_reg(RegTimeStep, 32'hFFFF_FFFF);
		send_force(32'h0010_0000);
		send_force(32'h8000_0000);
		send_force(32'h7FFF_FFFF);
		send_force(32'hFFF0_0000);
		drain();

		// A zero mass divides by one LSB and saturates.
		write_reg(RegMass, 32'd0);
		send_force(32'h0000_0001);
		send_force(32'h8000_0000);
		drain();
		write_reg(RegMethod, MethodEuler);
		send_force(32'h7FFF_FFFF);
		drain();

		// Heaviest mass, strongest damping, zero step.
		write_reg(RegMass, 32'hFFFF_FFFF);
		write_reg(RegDamping, 32'hFFFF_FFFF);
		write_reg(RegTimeStep, 32'd0);
		send_force(32'h7FFF_FFFF);
		send_force(32'h8000_0000);
		drain();

		// Tiny mass with full damping so the damping term hits its clamp.
		write_reg(RegMass, 32'd1);
		write_reg(RegTimeStep, 32'h8000_0000);
		send_force(32'h0000_0000);
		send_force(32'h7FFF_FFFF);
		send_force(32'h8000_0000);
		drain();
		write_reg(RegMethod, MethodRk4);
		send_force(32'h8000_0000);
		send_force(32'h0000_0000);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			random_settings();
			if (phase == 11) gaps_on = 1'b0;
			for (int n = 0; n < 152; n++) send_force(pick_force());
			drain();
		end

		repeat (500) @(posedge clk);
		if (errors == 0) begin
			$display("[damped_mass_integrator_unit] OK");
		end else begin
			$display("[damped_mass_integrator_unit] ERROR");
		end
		$finish;
	end
endmodule

// File: files.f
src/dmi_pkg.sv
src/damped_mass_integrator_unit.sv
test/tb_top.sv
